>>> rtl/fgn_pkg.sv
// shared types, constants and lookup functions of the fractal gradient noise block
package fgn_pkg;

	localparam int MAX_OCTAVES = 4;
	localparam int FRAC_BITS   = 16;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int FADE_15     = 15 << FRAC_BITS;
	localparam int FADE_10     = 10 << FRAC_BITS;
	localparam int FREQ_W      = 20;
	localparam int AMPL_W      = 17;
	localparam int LANE_STAGES = 12;
	localparam int CNT_W       = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_OCTAVE_COUNT = 3'd0,
		REG_PERSISTENCE  = 3'd1,
		REG_LACUNARITY   = 3'd2,
		REG_INV_SCALE    = 3'd3,
		REG_OFFSETS_X    = 3'd4,
		REG_OFFSETS_Y    = 3'd5
	} cfg_reg_e;

	// one point after scaling, as it waits between front and back
	typedef struct packed {
		logic [47:0]      px;
		logic [47:0]      py;
		logic [CNT_W-1:0] cnt;
	} item_t;

	// per-octave constants derived from the configuration
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [AMPL_W-1:0] ampl;
		logic [15:0]       ox;
		logic [15:0]       oy;
	} lane_cfg_t;

	localparam logic [7:0] PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180
	};

	function automatic logic [7:0] perm_rd(input logic [7:0] a);
		return PERM[a];
	endfunction

	// diagonal gradient dotted with the corner distance
	function automatic logic signed [18:0] grad(input logic [1:0] h,
			input logic signed [17:0] dx, input logic signed [17:0] dy);
		logic signed [18:0] ex;
		logic signed [18:0] ey;
		logic signed [18:0] r;
		ex = {dx[17], dx};
		ey = {dy[17], dy};
		case (h)
			2'd0:    r = ex + ey;
			2'd1:    r = ey - ex;
			2'd2:    r = ex - ey;
			default: r = -ex - ey;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/fgn_front.sv
// front end: takes points, scales them by the reciprocal scale, clamps the octave count
module fgn_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,   // x_coord[31:0], y_coord[63:32]
	input  logic [2:0]                  octave_count,
	input  logic [23:0]                 inv_scale,
	input  logic                        q_full,
	output logic                        q_push,
	output fgn_pkg::item_t              q_wdata
);
	import fgn_pkg::*;

	logic               vld_s1;
	logic [47:0]        px_s1;
	logic [47:0]        py_s1;
	logic [CNT_W-1:0]   cnt_s1;
	logic signed [56:0] pxf;
	logic signed [56:0] pyf;
	logic [CNT_W-1:0]   cnt_c;

	// signed point times unsigned reciprocal scale
	assign pxf = $signed(s_tdata[31:0]) * $signed({1'b0, inv_scale});
	assign pyf = $signed(s_tdata[63:32]) * $signed({1'b0, inv_scale});
	assign cnt_c = (octave_count > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES) : octave_count;

	assign s_tready = !vld_s1 || !q_full;
	assign q_push   = vld_s1 && !q_full;
	assign q_wdata  = '{px: px_s1, py: py_s1, cnt: cnt_s1};

	// valid of the scaling stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// payload of the scaling stage
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			px_s1  <= pxf[47:0];
			py_s1  <= pyf[47:0];
			cnt_s1 <= cnt_c;
		end
	end

endmodule

>>> rtl/fgn_queue.sv
// short request queue between the front end and the octave pipeline
module fgn_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fgn_pkg::item_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output fgn_pkg::item_t rdata
);
	import fgn_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

>>> rtl/fgn_octave.sv
// one octave lane: sample coordinate, hashing, fade, interpolation and amplitude weight
module fgn_octave (
	input  logic                clk,
	input  logic                en,
	input  logic [47:0]         px,
	input  logic [47:0]         py,
	input  fgn_pkg::lane_cfg_t  cfg,
	output logic signed [37:0]  weighted
);
	import fgn_pkg::*;

	// stage 1: frequency products
	logic [43:0] mlx, mhx, mly, mhy;
	logic [43:0] lox_s1, loy_s1;
	logic [23:0] hix_s1, hiy_s1;
	// stage 2: wrapped sample point
	logic [23:0] sx_s2, sy_s2;
	// stage 3: first hash level, fade first step
	logic [7:0]         p0_s3, p1_s3, iy_s3;
	logic [15:0]        fx_s3, fy_s3;
	logic signed [21:0] ax, ay;
	logic signed [38:0] tax_c, tay_c;
	logic signed [38:0] tax_s3, tay_s3;
	logic [31:0]        ttx_s3, tty_s3;
	// stage 4: corner hashes, fade second step
	logic [7:0]         h00_s4, h01_s4, h10_s4, h11_s4;
	logic [15:0]        fx_s4, fy_s4;
	logic signed [21:0] bx_s4, by_s4;
	logic [31:0]        t3x_s4, t3y_s4;
	// stage 5: gradients, fade product
	logic signed [17:0] dxa, dxb, dya, dyb;
	logic signed [18:0] d00_s5, d01_s5, d10_s5, d11_s5;
	logic signed [38:0] upx_s5, upy_s5;
	// stages 6 to 12: interpolation and weighting
	logic signed [17:0] u_s6, v_s6, v_s7, v_s8, v_s9;
	logic signed [19:0] e0_s6, e1_s6;
	logic signed [18:0] d00_s6, d01_s6, d00_s7, d01_s7;
	logic signed [37:0] m0_s7, m1_s7;
	logic signed [21:0] x0c, x1c;
	logic signed [19:0] x0_s8, x1_s8, x0_s9, x0_s10;
	logic signed [19:0] dyy_s9;
	logic signed [37:0] mv_s10;
	logic signed [21:0] nzc;
	logic signed [19:0] nz_s11;
	logic signed [37:0] w_s12;

	assign mlx = px[23:0] * cfg.freq;
	assign mhx = px[47:24] * cfg.freq;
	assign mly = py[23:0] * cfg.freq;
	assign mhy = py[47:24] * cfg.freq;

	assign ax    = $signed(22'(6 * {6'b0, sx_s2[15:0]}) - 22'(FADE_15));
	assign ay    = $signed(22'(6 * {6'b0, sy_s2[15:0]}) - 22'(FADE_15));
	assign tax_c = $signed({1'b0, sx_s2[15:0]}) * ax;
	assign tay_c = $signed({1'b0, sy_s2[15:0]}) * ay;

	assign dxa = $signed({2'b0, fx_s4});
	assign dya = $signed({2'b0, fy_s4});
	assign dxb = dxa - 18'(ONE);
	assign dyb = dya - 18'(ONE);

	assign x0c = {{3{d00_s7[18]}}, d00_s7} + m0_s7[37:16];
	assign x1c = {{3{d01_s7[18]}}, d01_s7} + m1_s7[37:16];
	assign nzc = {{2{x0_s10[19]}}, x0_s10} + mv_s10[37:16];

	assign weighted = w_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			// point times frequency, only bits 47:24 of the product matter
			lox_s1 <= mlx;
			loy_s1 <= mly;
			hix_s1 <= mhx[23:0];
			hiy_s1 <= mhy[23:0];
			// add the octave offset, wrap to 256 grid units
			sx_s2 <= {4'b0, lox_s1[43:24]} + hix_s1 + {cfg.ox, 8'b0};
			sy_s2 <= {4'b0, loy_s1[43:24]} + hiy_s1 + {cfg.oy, 8'b0};
			// column hashes and fade t*(6t-15), t*t
			p0_s3  <= perm_rd(sx_s2[23:16]);
			p1_s3  <= perm_rd(sx_s2[23:16] + 8'd1);
			iy_s3  <= sy_s2[23:16];
			fx_s3  <= sx_s2[15:0];
			fy_s3  <= sy_s2[15:0];
			tax_s3 <= tax_c;
			tay_s3 <= tay_c;
			ttx_s3 <= sx_s2[15:0] * sx_s2[15:0];
			tty_s3 <= sy_s2[15:0] * sy_s2[15:0];
			// corner hashes, fade polynomial tail and t^3
			h00_s4 <= perm_rd(p0_s3 + iy_s3);
			h01_s4 <= perm_rd(p0_s3 + iy_s3 + 8'd1);
			h10_s4 <= perm_rd(p1_s3 + iy_s3);
			h11_s4 <= perm_rd(p1_s3 + iy_s3 + 8'd1);
			fx_s4  <= fx_s3;
			fy_s4  <= fy_s3;
			bx_s4  <= $signed(tax_s3[37:16]) + 22'(FADE_10);
			by_s4  <= $signed(tay_s3[37:16]) + 22'(FADE_10);
			t3x_s4 <= ttx_s3[31:16] * fx_s3;
			t3y_s4 <= tty_s3[31:16] * fy_s3;
			// gradients and fade product
			d00_s5 <= grad(h00_s4[1:0], dxa, dya);
			d01_s5 <= grad(h01_s4[1:0], dxa, dyb);
			d10_s5 <= grad(h10_s4[1:0], dxb, dya);
			d11_s5 <= grad(h11_s4[1:0], dxb, dyb);
			upx_s5 <= $signed({1'b0, t3x_s4[31:16]}) * bx_s4;
			upy_s5 <= $signed({1'b0, t3y_s4[31:16]}) * by_s4;
			// fade weights and x differences
			u_s6   <= upx_s5[33:16];
			v_s6   <= upy_s5[33:16];
			e0_s6  <= {d10_s5[18], d10_s5} - {d00_s5[18], d00_s5};
			e1_s6  <= {d11_s5[18], d11_s5} - {d01_s5[18], d01_s5};
			d00_s6 <= d00_s5;
			d01_s6 <= d01_s5;
			// x lerp products
			m0_s7  <= u_s6 * e0_s6;
			m1_s7  <= u_s6 * e1_s6;
			d00_s7 <= d00_s6;
			d01_s7 <= d01_s6;
			v_s7   <= v_s6;
			// x lerp sums
			x0_s8 <= x0c[19:0];
			x1_s8 <= x1c[19:0];
			v_s8  <= v_s7;
			// y difference
			dyy_s9 <= x1_s8 - x0_s8;
			x0_s9  <= x0_s8;
			v_s9   <= v_s8;
			// y lerp
			mv_s10 <= v_s9 * dyy_s9;
			x0_s10 <= x0_s9;
			nz_s11 <= nzc[19:0];
			// amplitude weight
			w_s12 <= nz_s11 * $signed({1'b0, cfg.ampl});
		end
	end

endmodule

>>> rtl/fgn_back.sv
// back end: octave lanes, octave sum, saturation and output register
module fgn_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  fgn_pkg::item_t              q_rdata,
	input  fgn_pkg::lane_cfg_t          lane_cfg [fgn_pkg::MAX_OCTAVES],
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata    // height[19:0], zero pad[23:20]
);
	import fgn_pkg::*;

	logic                     en;
	logic                     vld_pipe_q [LANE_STAGES];
	logic [CNT_W-1:0]         cnt_pipe_q [LANE_STAGES];
	logic signed [37:0]       wt [MAX_OCTAVES];
	logic signed [23:0]       sum_c;
	logic signed [23:0]       sum_s13;
	logic                     vld_s13;
	logic                     out_vld_q;
	logic [19:0]              height_q;

	assign en       = !out_vld_q || m_tready;
	assign q_pop    = en && !q_empty;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0, height_q};

	// one lane per octave
	for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
		fgn_octave u_oct (
			.clk      (clk),
			.en       (en),
			.px       (q_rdata.px),
			.py       (q_rdata.py),
			.cfg      (lane_cfg[o]),
			.weighted (wt[o])
		);
	end

	// sum of the active octaves
	always_comb begin
		sum_c = '0;
		for (int o = 0; o < MAX_OCTAVES; o++) begin
			if (CNT_W'(o) < cnt_pipe_q[LANE_STAGES-1]) begin
				sum_c = sum_c + 24'($signed(wt[o][37:16]));
			end
		end
	end

	// valid pipeline alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_STAGES; i++) vld_pipe_q[i] <= 1'b0;
			vld_s13   <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_pipe_q[0] <= !q_empty;
			for (int i = 1; i < LANE_STAGES; i++) vld_pipe_q[i] <= vld_pipe_q[i-1];
			vld_s13   <= vld_pipe_q[LANE_STAGES-1];
			out_vld_q <= vld_s13;
		end
	end

	// octave count, sum and saturated height
	always_ff @(posedge clk) begin
		if (en) begin
			cnt_pipe_q[0] <= q_rdata.cnt;
			for (int i = 1; i < LANE_STAGES; i++) cnt_pipe_q[i] <= cnt_pipe_q[i-1];
			sum_s13 <= sum_c;
			if (sum_s13 > 24'sd524287) begin
				height_q <= 20'h7ffff;
			end else if (sum_s13 < -24'sd524288) begin
				height_q <= 20'h80000;
			end else begin
				height_q <= sum_s13[19:0];
			end
		end
	end

endmodule

>>> rtl/fractal_gradient_noise_2d.sv
// top level of the fractal gradient noise generator: registers, front, queue and back
// path of an accepted point: scaling register, queue entry, lane stages, sum register and height register
// throughput: one point per cycle while the output is not stalled; every octave has its own lane of multipliers
// the four-entry queue absorbs the front stage while the output stalls
// reset: asynchronous, clears all valid state and loads the register defaults
// derived frequencies and amplitudes of the higher octaves are registered in a chain and settle after a register write
module fractal_gradient_noise_2d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // x_coord[31:0], y_coord[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // height[19:0], zero pad[23:20]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import fgn_pkg::*;

	logic [2:0]        octave_count_q;
	logic [15:0]       persistence_q;
	logic [11:0]       lacunarity_q;
	logic [23:0]       inv_scale_q;
	logic [63:0]       offsets_x_q;
	logic [63:0]       offsets_y_q;
	logic [FREQ_W-1:0] freq [MAX_OCTAVES];
	logic [AMPL_W-1:0] ampl [MAX_OCTAVES];
	lane_cfg_t         lane_cfg [MAX_OCTAVES];
	logic              q_full, q_push, q_empty, q_pop;
	item_t             q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= 3'd4;
			persistence_q  <= 16'd32768;
			lacunarity_q   <= 12'd512;
			inv_scale_q    <= 24'd6554;
			offsets_x_q    <= '0;
			offsets_y_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OCTAVE_COUNT: octave_count_q <= cfg_data[2:0];
				REG_PERSISTENCE:  persistence_q  <= cfg_data[15:0];
				REG_LACUNARITY:   lacunarity_q   <= cfg_data[11:0];
				REG_INV_SCALE:    inv_scale_q    <= cfg_data[23:0];
				REG_OFFSETS_X:    offsets_x_q    <= cfg_data;
				REG_OFFSETS_Y:    offsets_y_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// per-octave frequency and amplitude, one multiply per octave step
	for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_scale
		if (o == 0) begin : g_first
			assign freq[o] = FREQ_W'(256);
			assign ampl[o] = AMPL_W'(ONE);
		end else if (o == 1) begin : g_second
			assign freq[o] = FREQ_W'(lacunarity_q);
			assign ampl[o] = AMPL_W'(persistence_q);
		end else begin : g_chain
			logic [FREQ_W-1:0] freq_q;
			logic [AMPL_W-1:0] ampl_q;
			logic [31:0]       fp;
			logic [32:0]       ap;
			assign fp = freq[o-1] * lacunarity_q;
			assign ap = ampl[o-1] * persistence_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					freq_q <= FREQ_W'(256 << o);
					ampl_q <= AMPL_W'(ONE >> o);
				end else begin
					freq_q <= fp[FREQ_W+7:8];
					ampl_q <= ap[AMPL_W+15:16];
				end
			end
			assign freq[o] = freq_q;
			assign ampl[o] = ampl_q;
		end
		assign lane_cfg[o] = '{freq: freq[o], ampl: ampl[o],
			ox: offsets_x_q[16*o +: 16], oy: offsets_y_q[16*o +: 16]};
	end

	fgn_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.octave_count (octave_count_q),
		.inv_scale    (inv_scale_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	fgn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	fgn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_rdata  (q_rdata),
		.lane_cfg (lane_cfg),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> rtl/fgn_checker.sv
// port-level checks of the fractal gradient noise generator and their binding
module fgn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a stalled height holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled height changed");

	// reset empties the output
	assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("height valid during reset");

	// padding above the height stays zero while a height is shown
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:20] == 4'b0)
		else $error("height padding not zero");

endmodule

bind fractal_gradient_noise_2d fgn_checker u_fgn_checker (.*);
